// File: hw/rtl/bssm_pkg.sv
// Shared types and constants of the barrier and semaphore sync manager.
package bssm_pkg;

    localparam int TableEntries = 16;
    localparam int MaxWaiters   = 63;
    localparam int NodeCount    = 64;
    localparam int EntW         = $clog2(TableEntries);
    localparam int QW           = 6;
    localparam int SlotW        = EntW + QW;
    localparam int CntW         = 18;
    localparam logic signed [CntW-1:0] CounterTop = 18'sd131071;

    typedef enum logic [1:0] {
        CMD_BARRIER   = 2'd0,
        CMD_SEM_ENTER = 2'd1,
        CMD_SEM_LEAVE = 2'd2,
        CMD_UNUSED    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_WAKE       = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_LIST_FULL  = 2'd2,
        ST_MISMATCH   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } t_state;

    typedef struct packed {
        logic                   is_sem;
        logic signed [CntW-1:0] counter;
        logic [15:0]            target;
        logic [QW-1:0]          head;
        logic [QW-1:0]          count;
    } t_entry;

endpackage

// File: hw/rtl/bssm_waiter_ram.sv
// Waiter list storage: one write port and one registered read port.
module bssm_waiter_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [bssm_pkg::SlotW-1:0]    i_waddr,
    input  logic [15:0]                   i_wdata,
    input  logic [bssm_pkg::SlotW-1:0]    i_raddr,
    output logic [15:0]                   o_rdata
);
    logic [15:0] mem [bssm_pkg::TableEntries * 64];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// File: hw/rtl/barrier_semaphore_sync_manager.sv
// Top level of the barrier and semaphore sync manager.
// A request other than the unused command is taken when start is high and busy
// is low. It passes through a key search state and an execute state; a barrier
// release then reads each queued waiter from the waiter memory, whose read is
// registered, in a read state and then an output state. Results appear
// for one cycle with o_valid; the receiver cannot stall them.
module barrier_semaphore_sync_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_object_key,
    input  logic [5:0]  i_source_node,
    input  logic [9:0]  i_thread_number,
    input  logic [15:0] i_initial_count,
    output logic        o_valid,
    output logic [5:0]  o_wake_node,
    output logic [9:0]  o_wake_thread,
    output logic [1:0]  o_status,
    output logic        o_last
);
    localparam int EW = bssm_pkg::EntW;
    localparam int QW = bssm_pkg::QW;
    localparam int CW = bssm_pkg::CntW;

    bssm_pkg::t_state r_state, n_state;

    logic [bssm_pkg::TableEntries-1:0] r_valid;
    logic [31:0] r_keys [bssm_pkg::TableEntries];
    bssm_pkg::t_entry r_ent_mem [bssm_pkg::TableEntries];

    logic [1:0]  r_cmd;
    logic [31:0] r_key;
    logic [5:0]  r_node;
    logic [9:0]  r_thr;
    logic [15:0] r_init;

    logic          r_hit, r_free;
    logic [EW-1:0] r_idx;
    logic [EW-1:0] r_free_idx;
    bssm_pkg::t_entry r_ent;
    logic [QW-1:0] r_head, r_left;

    logic          hit, free_found;
    logic [EW-1:0] hit_idx, free_idx;
    always_comb begin
        hit = 1'b0; free_found = 1'b0; hit_idx = '0; free_idx = '0;
        for (int i = 0; i < bssm_pkg::TableEntries; i++) begin
            if (r_valid[i]) begin
                if (!hit && r_keys[i] == r_key) begin
                    hit = 1'b1; hit_idx = EW'(i);
                end
            end else if (!free_found) begin
                free_found = 1'b1; free_idx = EW'(i);
            end
        end
    end

    logic [15:0] ram_rdata, ram_wdata;
    logic [bssm_pkg::SlotW-1:0] ram_waddr, ram_raddr;
    logic ram_we;

    bssm_waiter_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    function automatic logic [QW-1:0] qinc(input logic [QW-1:0] a);
        logic [QW:0] s;
        s = {1'b0, a} + 7'd1;
        if (s >= (QW+1)'(bssm_pkg::MaxWaiters)) s = s - (QW+1)'(bssm_pkg::MaxWaiters);
        return s[QW-1:0];
    endfunction

    function automatic logic [QW-1:0] qadd(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [QW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (QW+1)'(bssm_pkg::MaxWaiters)) s = s - (QW+1)'(bssm_pkg::MaxWaiters);
        return s[QW-1:0];
    endfunction

    // Entry as seen in the execute cycle, new entries already initialized.
    bssm_pkg::t_entry cur;
    logic [EW-1:0] eidx;
    logic err_mm, err_full;
    logic want_sem;
    always_comb begin
        want_sem = (r_cmd != bssm_pkg::CMD_BARRIER);
        eidx = r_hit ? r_idx : r_free_idx;
        cur = r_ent;
        if (!r_hit) begin
            cur.is_sem  = want_sem;
            cur.counter = want_sem ? CW'($signed({1'b0, r_init})) : '0;
            cur.target  = r_init;
            cur.head    = '0;
            cur.count   = '0;
        end
        err_mm   = r_hit && (r_ent.is_sem != want_sem);
        err_full = !r_hit && !r_free;
    end

    logic [CW:0] cnt_p1;
    logic signed [CW-1:0] cnt_m1;
    logic bar_rel, sem_ok, q_full;
    always_comb begin
        cnt_p1  = {1'b0, cur.counter} + (CW+1)'(1);
        cnt_m1  = cur.counter - CW'(1);
        bar_rel = cnt_p1 >= (CW+1)'(cur.target);
        sem_ok  = !cnt_m1[CW-1];
        q_full  = cur.count >= QW'(bssm_pkg::MaxWaiters);
    end

    logic        n_valid, n_last;
    logic [5:0]  n_wnode;
    logic [9:0]  n_wthr;
    logic [1:0]  n_status;
    logic        ent_we;
    bssm_pkg::t_entry ent_wdata;
    logic        alloc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bssm_pkg::S_IDLE:
                if (start && i_command != bssm_pkg::CMD_UNUSED
                    && 32'(i_source_node) < 32'(bssm_pkg::NodeCount))
                    n_state = bssm_pkg::S_LOOKUP;
            bssm_pkg::S_LOOKUP:
                n_state = bssm_pkg::S_EXEC;
            bssm_pkg::S_EXEC:
                if (!err_mm && !err_full && r_cmd == bssm_pkg::CMD_BARRIER && bar_rel
                    && cur.count != '0)
                    n_state = bssm_pkg::S_DRAIN_RD;
                else
                    n_state = bssm_pkg::S_IDLE;
            bssm_pkg::S_DRAIN_RD:
                n_state = bssm_pkg::S_DRAIN_OUT;
            bssm_pkg::S_DRAIN_OUT:
                n_state = (r_left == QW'(1)) ? bssm_pkg::S_IDLE : bssm_pkg::S_DRAIN_RD;
            default:
                n_state = bssm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = 1'b0; n_last = 1'b0; n_wnode = r_node; n_wthr = r_thr;
        n_status = bssm_pkg::ST_WAKE;
        ent_we = 1'b0; ent_wdata = cur; alloc = 1'b0;
        ram_we = 1'b0; ram_wdata = {r_node, r_thr};
        ram_waddr = {eidx, qadd(cur.head, cur.count)};
        ram_raddr = {r_idx, r_head};
        unique case (r_state)
            bssm_pkg::S_EXEC: begin
                ram_raddr = {eidx, cur.head};
                if (err_mm) begin
                    n_valid = 1'b1; n_last = 1'b1; n_status = bssm_pkg::ST_MISMATCH;
                end else if (err_full) begin
                    n_valid = 1'b1; n_last = 1'b1; n_status = bssm_pkg::ST_TABLE_FULL;
                end else begin
                    alloc = !r_hit;
                    ent_we = 1'b1;
                    unique case (r_cmd)
                        bssm_pkg::CMD_BARRIER: begin
                            if (bar_rel) begin
                                ent_wdata.counter = '0;
                                ent_wdata.head = '0;
                                ent_wdata.count = '0;
                                n_valid = 1'b1; n_last = (cur.count == '0);
                            end else if (q_full) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                n_status = bssm_pkg::ST_LIST_FULL;
                            end else begin
                                ent_wdata.counter = cnt_p1[CW-1:0];
                                ent_wdata.count = cur.count + QW'(1);
                                ram_we = 1'b1;
                            end
                        end
                        bssm_pkg::CMD_SEM_ENTER: begin
                            if (sem_ok) begin
                                ent_wdata.counter = cnt_m1;
                                n_valid = 1'b1; n_last = 1'b1;
                            end else if (q_full) begin
                                n_valid = 1'b1; n_last = 1'b1;
                                n_status = bssm_pkg::ST_LIST_FULL;
                            end else begin
                                ent_wdata.counter = cnt_m1;
                                ent_wdata.count = cur.count + QW'(1);
                                ram_we = 1'b1;
                            end
                        end
                        default: begin
                            if (cur.counter < bssm_pkg::CounterTop)
                                ent_wdata.counter = cnt_p1[CW-1:0];
                            if (cur.count != '0) begin
                                ent_wdata.head = qinc(cur.head);
                                ent_wdata.count = cur.count - QW'(1);
                            end
                        end
                    endcase
                end
            end
            bssm_pkg::S_DRAIN_OUT: begin
                n_valid = 1'b1;
                n_wnode = ram_rdata[15:10];
                n_wthr = ram_rdata[9:0];
                n_last = (r_left == QW'(1));
            end
            default: ;
        endcase
    end

    // A leave reads the queue head through the waiter memory in the execute
    // cycle; a matching barrier or enter does not use that read.
    logic r_leave_pop;
    logic [15:0] leave_word;
    assign leave_word = ram_rdata;

    logic r_o_valid, r_o_last;
    logic [5:0] r_o_node;
    logic [9:0] r_o_thr;
    logic [1:0] r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bssm_pkg::S_IDLE;
            r_valid <= '0;
            r_o_valid <= 1'b0;
            r_leave_pop <= 1'b0;
        end else begin
            r_state <= n_state;
            r_o_valid <= n_valid || r_leave_pop;
            if (alloc) r_valid[eidx] <= 1'b1;
            r_leave_pop <= (r_state == bssm_pkg::S_EXEC) && ent_we
                && (r_cmd == bssm_pkg::CMD_SEM_LEAVE) && (cur.count != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bssm_pkg::S_IDLE) begin
            r_cmd <= i_command; r_key <= i_object_key; r_node <= i_source_node;
            r_thr <= i_thread_number; r_init <= i_initial_count;
        end
        if (r_state == bssm_pkg::S_LOOKUP) begin
            r_hit <= hit; r_free <= free_found; r_idx <= hit_idx; r_free_idx <= free_idx;
            r_ent <= r_ent_mem[hit_idx];
        end
        if (ent_we) begin
            r_ent_mem[eidx] <= ent_wdata;
            if (alloc) r_keys[eidx] <= r_key;
        end
        if (r_state == bssm_pkg::S_EXEC) begin
            r_idx <= eidx;
            r_head <= cur.head;
            r_left <= cur.count;
        end else if (r_state == bssm_pkg::S_DRAIN_OUT) begin
            r_head <= qinc(r_head);
            r_left <= r_left - QW'(1);
        end
        if (r_leave_pop) begin
            r_o_node <= leave_word[15:10]; r_o_thr <= leave_word[9:0];
            r_o_status <= bssm_pkg::ST_WAKE; r_o_last <= 1'b1;
        end else begin
            r_o_node <= n_wnode; r_o_thr <= n_wthr;
            r_o_status <= n_status; r_o_last <= n_last;
        end
    end

    assign busy          = (r_state != bssm_pkg::S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_wake_node   = r_o_node;
    assign o_wake_thread = r_o_thr;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;
endmodule
